// ===== src/lmcf_pkg.sv =====
// ----------------------------------------------------------------------------
// lmcf_pkg
// Shared types and constants for the cascaded LED matrix frame buffer:
// opcodes, the classified command that crosses the queue, and the payloads.
// ----------------------------------------------------------------------------
`default_nettype none

package lmcf_pkg;

  // Chain geometry
  localparam int DISPLAYS_DEF = 4;
  localparam int MAX_DISPLAYS = 4;
  localparam int ROWS         = 8;
  localparam int ROW_W        = $clog2(ROWS);
  localparam int DISP_W       = $clog2(MAX_DISPLAYS);
  localparam int FRAME_W      = 16;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [FRAME_W-1:0] NOOP_FRAME = 16'h0000;

  // Opcodes on the input channel
  localparam logic [2:0] OP_SET_ROW     = 3'd0;
  localparam logic [2:0] OP_SET_DOT     = 3'd1;
  localparam logic [2:0] OP_SHIFT_LEFT  = 3'd2;
  localparam logic [2:0] OP_SHIFT_RIGHT = 3'd3;
  localparam logic [2:0] OP_REFRESH     = 3'd4;
  localparam logic [2:0] OP_CLEAR       = 3'd5;
  localparam logic [2:0] OP_BROADCAST   = 3'd6;

  // Command kinds after classification
  typedef enum logic [2:0] {
    K_SET_ROW,
    K_SET_DOT,
    K_SHIFT_LEFT,
    K_SHIFT_RIGHT,
    K_REFRESH,
    K_CLEAR,
    K_BROADCAST
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [ROW_W-1:0]  row;
    logic [DISP_W-1:0] disp;
    logic [2:0]        bit_pos;
    logic              pixel;
    logic [7:0]        row_bits;
    logic [3:0]        reg_address;
    logic [7:0]        reg_data;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic [2:0] row_index;
    logic [1:0] display_index;
    logic [4:0] column_index;
    logic       pixel_on;
    logic [7:0] row_bits;
    logic [3:0] reg_address;
    logic [7:0] reg_data;
  } in_item_t;

  typedef struct packed {
    logic [MAX_DISPLAYS*FRAME_W-1:0] frame_word;
    logic                            last_of_run;
  } out_item_t;

endpackage

`default_nettype wire

// ===== src/lmcf_front.sv =====
// ----------------------------------------------------------------------------
// lmcf_front
// Accepts operations, drops those aimed outside the chain or with an unused
// opcode, and turns the rest into commands for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lmcf_front #(
  parameter int DISPLAYS = lmcf_pkg::DISPLAYS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire lmcf_pkg::in_item_t in_data,
  input  wire logic              q_full,
  output logic                   busy,
  output logic                   push,
  output lmcf_pkg::cmd_t         push_cmd
);

  logic accept;
  logic keep;

  assign busy   = q_full;
  assign accept = start && !busy;

  // Classify the operation
  always_comb begin
    keep              = 1'b1;
    push_cmd.kind     = lmcf_pkg::K_REFRESH;
    push_cmd.row      = in_data.row_index;
    push_cmd.disp     = in_data.display_index;
    push_cmd.bit_pos  = in_data.column_index[2:0];
    push_cmd.pixel    = in_data.pixel_on;
    push_cmd.row_bits = in_data.row_bits;
    push_cmd.reg_address = in_data.reg_address;
    push_cmd.reg_data    = in_data.reg_data;
    unique case (in_data.op)
      lmcf_pkg::OP_SET_ROW: begin
        push_cmd.kind = lmcf_pkg::K_SET_ROW;
        keep = int'(in_data.display_index) < DISPLAYS;
      end
      lmcf_pkg::OP_SET_DOT: begin
        push_cmd.kind = lmcf_pkg::K_SET_DOT;
        push_cmd.disp = in_data.column_index[4:3];
        keep = int'(in_data.column_index[4:3]) < DISPLAYS;
      end
      lmcf_pkg::OP_SHIFT_LEFT:  push_cmd.kind = lmcf_pkg::K_SHIFT_LEFT;
      lmcf_pkg::OP_SHIFT_RIGHT: push_cmd.kind = lmcf_pkg::K_SHIFT_RIGHT;
      lmcf_pkg::OP_REFRESH:     push_cmd.kind = lmcf_pkg::K_REFRESH;
      lmcf_pkg::OP_CLEAR:       push_cmd.kind = lmcf_pkg::K_CLEAR;
      lmcf_pkg::OP_BROADCAST:   push_cmd.kind = lmcf_pkg::K_BROADCAST;
      default:                  keep = 1'b0;
    endcase
  end

  assign push = accept && keep;

  // A push never meets a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("push into full command queue");

endmodule

`default_nettype wire

// ===== src/lmcf_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// lmcf_cmd_fifo
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lmcf_cmd_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire lmcf_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output logic                full,
  output logic                empty,
  output lmcf_pkg::cmd_t      head_cmd
);

  localparam int PTR_W = (lmcf_pkg::QUEUE_DEPTH > 1) ? $clog2(lmcf_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(lmcf_pkg::QUEUE_DEPTH + 1);

  lmcf_pkg::cmd_t     entry_r [lmcf_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;

  assign full     = count_r == CNT_W'(lmcf_pkg::QUEUE_DEPTH);
  assign empty    = count_r == '0;
  assign head_cmd = entry_r[rd_ptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (int'(wr_ptr_r) == lmcf_pkg::QUEUE_DEPTH - 1) ? '0
                                                                    : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (int'(rd_ptr_r) == lmcf_pkg::QUEUE_DEPTH - 1) ? '0
                                                                    : rd_ptr_r + PTR_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/lmcf_back.sv =====
// ----------------------------------------------------------------------------
// lmcf_back
// Holds the frame buffer, applies each command when it leaves the queue and
// then sequences its chip-select transactions, one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lmcf_back #(
  parameter int DISPLAYS = lmcf_pkg::DISPLAYS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  input  wire lmcf_pkg::cmd_t head_cmd,
  output logic                pop,
  input  wire logic           cfg_we,
  input  wire logic           cfg_wdata,
  output logic                out_valid,
  output lmcf_pkg::out_item_t out_data
);

  localparam int DW    = (DISPLAYS > 1) ? $clog2(DISPLAYS) : 1;
  localparam int ROW_W = lmcf_pkg::ROW_W;
  localparam int FW    = lmcf_pkg::FRAME_W;
  localparam int CW    = DISPLAYS * 8;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;
  typedef enum logic [1:0] {M_ROW, M_REFRESH, M_CLEAR, M_BCAST} mode_t;

  state_t              state_r;
  mode_t               mode_r;
  logic [ROW_W-1:0]    row_r;
  logic [DW-1:0]       disp_r;
  logic [7:0]          baddr_r;
  logic [7:0]          bdata_r;
  logic                invert_r;
  logic                out_valid_r;
  lmcf_pkg::out_item_t out_data_r;

  logic [7:0] fb_r      [lmcf_pkg::ROWS][DISPLAYS];
  logic [7:0] shl_rows  [lmcf_pkg::ROWS][DISPLAYS];
  logic [7:0] shr_rows  [lmcf_pkg::ROWS][DISPLAYS];

  logic                                     run_last;
  logic                                     disp_end;
  logic [lmcf_pkg::MAX_DISPLAYS*FW-1:0]     frame_nxt;
  logic [DW-1:0]                            cmd_disp;

  assign pop       = (state_r == ST_IDLE) && !q_empty;
  assign cmd_disp  = head_cmd.disp[DW-1:0];
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r <= 1'b0;
    end else if (cfg_we) begin
      invert_r <= cfg_wdata;
    end
  end

  // Shifted copies of every row, carry crossing the displays
  // (display 0 sits in the low byte so a left shift feeds it from display 1)
  always_comb begin
    logic [CW-1:0] rowv;
    logic [CW-1:0] lv;
    logic [CW-1:0] rv;
    for (int r = 0; r < lmcf_pkg::ROWS; r++) begin
      for (int d = 0; d < DISPLAYS; d++) begin
        rowv[d*8 +: 8] = fb_r[r][d];
      end
      lv = rowv >> 1;
      rv = rowv << 1;
      for (int d = 0; d < DISPLAYS; d++) begin
        shl_rows[r][d] = lv[d*8 +: 8];
        shr_rows[r][d] = rv[d*8 +: 8];
      end
    end
  end

  // Frame buffer update as a command leaves the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < lmcf_pkg::ROWS; r++) begin
        for (int d = 0; d < DISPLAYS; d++) begin
          fb_r[r][d] <= 8'h00;
        end
      end
    end else if (pop) begin
      unique case (head_cmd.kind)
        lmcf_pkg::K_SET_ROW: fb_r[head_cmd.row][cmd_disp] <= head_cmd.row_bits;
        lmcf_pkg::K_SET_DOT: begin
          fb_r[head_cmd.row][cmd_disp][head_cmd.bit_pos] <= head_cmd.pixel;
        end
        lmcf_pkg::K_SHIFT_LEFT:  fb_r <= shl_rows;
        lmcf_pkg::K_SHIFT_RIGHT: fb_r <= shr_rows;
        lmcf_pkg::K_CLEAR: begin
          for (int r = 0; r < lmcf_pkg::ROWS; r++) begin
            for (int d = 0; d < DISPLAYS; d++) begin
              fb_r[r][d] <= 8'h00;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // End-of-run detection
  assign disp_end = disp_r == DW'(DISPLAYS - 1);
  always_comb begin
    unique case (mode_r)
      M_REFRESH: run_last = (row_r == ROW_W'(lmcf_pkg::ROWS - 1)) && disp_end;
      M_CLEAR:   run_last = row_r == ROW_W'(lmcf_pkg::ROWS - 1);
      default:   run_last = 1'b1;
    endcase
  end

  // Transaction forming
  always_comb begin
    logic [7:0] row_addr;
    logic [7:0] row_byte;
    logic [7:0] b_addr;
    logic [7:0] b_data;
    row_addr  = {{(8-ROW_W){1'b0}}, row_r} + 8'd1;
    row_byte  = fb_r[row_r][disp_r] ^ {8{invert_r}};
    b_addr    = (mode_r == M_CLEAR) ? row_addr : baddr_r;
    b_data    = (mode_r == M_CLEAR) ? 8'h00 : bdata_r;
    frame_nxt = '0;
    for (int i = 0; i < lmcf_pkg::MAX_DISPLAYS; i++) begin
      frame_nxt[i*FW +: FW] = lmcf_pkg::NOOP_FRAME;
      if (mode_r == M_CLEAR || mode_r == M_BCAST) begin
        if (i < DISPLAYS) begin
          frame_nxt[i*FW +: FW] = {b_addr, b_data};
        end
      end else if (i == DISPLAYS - 1 - int'(disp_r)) begin
        frame_nxt[i*FW +: FW] = {row_addr, row_byte};
      end
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= M_ROW;
      row_r       <= '0;
      disp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r            <= state_r == ST_RUN;
      out_data_r.frame_word  <= frame_nxt;
      out_data_r.last_of_run <= run_last;
      unique case (state_r)
        ST_IDLE: begin
          if (pop) begin
            state_r <= ST_RUN;
            baddr_r <= {4'h0, head_cmd.reg_address};
            bdata_r <= head_cmd.reg_data;
            row_r   <= '0;
            disp_r  <= '0;
            unique case (head_cmd.kind)
              lmcf_pkg::K_SET_ROW, lmcf_pkg::K_SET_DOT: begin
                mode_r <= M_ROW;
                row_r  <= head_cmd.row;
                disp_r <= cmd_disp;
              end
              lmcf_pkg::K_CLEAR:     mode_r <= M_CLEAR;
              lmcf_pkg::K_BROADCAST: mode_r <= M_BCAST;
              default:               mode_r <= M_REFRESH;
            endcase
          end
        end
        ST_RUN: begin
          if (run_last) begin
            state_r <= ST_IDLE;
          end else if (mode_r == M_REFRESH) begin
            if (disp_end) begin
              disp_r <= '0;
              row_r  <= row_r + ROW_W'(1);
            end else begin
              disp_r <= disp_r + DW'(1);
            end
          end else begin
            row_r <= row_r + ROW_W'(1);
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Every run cycle produces exactly one strobed transfer
  a_run_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |=> out_valid_r)
    else $error("run cycle without result strobe");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |=> !out_valid_r)
    else $error("result strobe while idle");

  // The final transfer of a run is flagged and ends the run
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && run_last) |=> (state_r == ST_IDLE && out_data_r.last_of_run))
    else $error("run end not flagged");

  a_pop_runs: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> state_r == ST_RUN)
    else $error("popped command not started");

endmodule

`default_nettype wire

// ===== src/led_matrix_chain_framebuffer_top.sv =====
// An operation is written into the queue, popped into the back end's sequencer state, and its
// first transfer then comes from the output register. Each operation holds the back end in its
// idle state and then for its transactions: one for row, dot and broadcast writes, one per row for
// clear, and one per row and display for refresh and shifts. The back end's one-transaction-per-cycle
// sequencer sets the rate; a 2-entry queue lets the front take operations while the back end runs.
// busy is high when it is full. Synchronous reset clears the frame buffer, the invert setting and the queue.
// ----------------------------------------------------------------------------
// led_matrix_chain_framebuffer_top
// Frame buffer and transaction former for a chain of 8x8 LED matrix drivers.
// ----------------------------------------------------------------------------
`default_nettype none

module led_matrix_chain_framebuffer_top #(
  parameter int DISPLAYS = lmcf_pkg::DISPLAYS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire lmcf_pkg::in_item_t in_data,
  output logic                    out_valid,
  output lmcf_pkg::out_item_t     out_data,
  input  wire logic               cfg_we,
  input  wire logic               cfg_wdata
);

  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;
  lmcf_pkg::cmd_t push_cmd;
  lmcf_pkg::cmd_t head_cmd;

  lmcf_front #(.DISPLAYS(DISPLAYS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_data  (in_data),
    .q_full   (q_full),
    .busy     (busy),
    .push     (push),
    .push_cmd (push_cmd)
  );

  lmcf_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head_cmd (head_cmd)
  );

  lmcf_back #(.DISPLAYS(DISPLAYS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .head_cmd  (head_cmd),
    .pop       (pop),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== bench/tb_led_matrix_chain_framebuffer_top.sv =====
// ----------------------------------------------------------------------------
// tb_led_matrix_chain_framebuffer_top
// Self-checking bench for the LED matrix chain frame buffer. Commands go in
// as directed and random bursts. A local copy of the frame buffer predicts
// every chip-select transfer, and each strobed transfer is checked in order.
// ----------------------------------------------------------------------------
module tb_led_matrix_chain_framebuffer_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         DISP_COUNT    = lmcf_pkg::DISPLAYS_DEF;
  localparam logic [2:0] OP_UNUSED     = 3'd7;
  localparam int         SETTLE_CYCLES = 40;
  localparam int         QUIET_LIMIT   = 2000;
  localparam int         RANDOM_ITEMS  = 385;
  localparam int         PHASES        = 5;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  lmcf_pkg::in_item_t  in_data;
  logic                out_valid;
  lmcf_pkg::out_item_t out_data;
  logic                cfg_we;
  logic                cfg_wdata;

  // Shadow of the display rows and the view setting
  logic [7:0]          shadow_rows [lmcf_pkg::ROWS][lmcf_pkg::MAX_DISPLAYS];
  logic                invert_on;
  lmcf_pkg::out_item_t pending_frames[$];
  int                  error_count = 0;
  int                  quiet_cycles = 0;

  led_matrix_chain_framebuffer_top #(
    .DISPLAYS(DISP_COUNT)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    error_count++;
  endtask

  // One row transfer: row address and stored byte, inverted if set, to one display, no-ops elsewhere
  function automatic logic [63:0] row_frame(input int r, input int d);
    logic [63:0] w;
    logic [7:0]  v;
    w = '0;
    v = shadow_rows[r][d];
    if (invert_on) v = ~v;
    w[16*(DISP_COUNT-1-d) +: 16] = {8'(r + 1), v};
    return w;
  endfunction

  function automatic logic [63:0] broadcast_frame(input logic [7:0] addr,
                                                  input logic [7:0] data);
    logic [63:0] w;
    w = '0;
    for (int i = 0; i < DISP_COUNT; i++) w[16*i +: 16] = {addr, data};
    return w;
  endfunction

  // Update the shadow buffer and queue the transfers one command causes
  task automatic predict_transfers(input lmcf_pkg::in_item_t cmd);
    logic [63:0]         words[$];
    logic [7:0]          v;
    logic [7:0]          carry;
    logic [7:0]          next_carry;
    int                  dd;
    bit                  full_refresh;
    lmcf_pkg::out_item_t item;
    full_refresh = 1'b0;
    case (cmd.op)
      lmcf_pkg::OP_SET_ROW: begin
        if (int'(cmd.display_index) < DISP_COUNT) begin
          shadow_rows[cmd.row_index][cmd.display_index] = cmd.row_bits;
          words.push_back(row_frame(int'(cmd.row_index), int'(cmd.display_index)));
        end
      end
      lmcf_pkg::OP_SET_DOT: begin
        dd = int'(cmd.column_index[4:3]);
        if (dd < DISP_COUNT) begin
          shadow_rows[cmd.row_index][dd][cmd.column_index[2:0]] = cmd.pixel_on;
          words.push_back(row_frame(int'(cmd.row_index), dd));
        end
      end
      lmcf_pkg::OP_SHIFT_LEFT: begin
        // LSB of display d+1 moves into bit 7 of display d
        for (int r = 0; r < lmcf_pkg::ROWS; r++) begin
          carry = 8'h00;
          for (int d = DISP_COUNT - 1; d >= 0; d--) begin
            v = shadow_rows[r][d];
            next_carry = {v[0], 7'b0};
            shadow_rows[r][d] = (v >> 1) | carry;
            carry = next_carry;
          end
        end
        full_refresh = 1'b1;
      end
      lmcf_pkg::OP_SHIFT_RIGHT: begin
        // MSB of display d-1 moves into bit 0 of display d
        for (int r = 0; r < lmcf_pkg::ROWS; r++) begin
          carry = 8'h00;
          for (int d = 0; d < DISP_COUNT; d++) begin
            v = shadow_rows[r][d];
            next_carry = {7'b0, v[7]};
            shadow_rows[r][d] = (v << 1) | carry;
            carry = next_carry;
          end
        end
        full_refresh = 1'b1;
      end
      lmcf_pkg::OP_REFRESH: full_refresh = 1'b1;
      lmcf_pkg::OP_CLEAR: begin
        // digit writes go out as plain broadcasts, never inverted
        for (int r = 0; r < lmcf_pkg::ROWS; r++)
          for (int d = 0; d < lmcf_pkg::MAX_DISPLAYS; d++) shadow_rows[r][d] = 8'h00;
        for (int a = 1; a <= 8; a++) words.push_back(broadcast_frame(8'(a), 8'h00));
      end
      lmcf_pkg::OP_BROADCAST:
        words.push_back(broadcast_frame({4'h0, cmd.reg_address}, cmd.reg_data));
      default: ;
    endcase
    if (full_refresh)
      for (int r = 0; r < lmcf_pkg::ROWS; r++)
        for (int d = 0; d < DISP_COUNT; d++) words.push_back(row_frame(r, d));
    foreach (words[k]) begin
      item.frame_word  = words[k];
      item.last_of_run = (k == words.size() - 1);
      pending_frames.push_back(item);
    end
  endtask

  // Result checker: each strobed transfer against the oldest prediction
  always @(posedge clk) begin : result_check
    lmcf_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_frames.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer %h", out_data.frame_word));
      end else begin
        want = pending_frames.pop_front();
        if (out_data.frame_word !== want.frame_word)
          report_mismatch($sformatf("frame_word %h, want %h",
                                    out_data.frame_word, want.frame_word));
        if (out_data.last_of_run !== want.last_of_run)
          report_mismatch($sformatf("last_of_run %b, want %b (frame %h)",
                                    out_data.last_of_run, want.last_of_run,
                                    want.frame_word));
      end
    end
  end

  // Watchdog: ends the run after a long stretch with no transfer either way
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one command and hold it until the block takes it; start stays high
  task automatic send_cmd(input lmcf_pkg::in_item_t cmd);
    start   <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (busy !== 1'b0);
    predict_transfers(cmd);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Wait for every predicted transfer, then let ignored commands retire
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_invert(input logic value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    invert_on = value;
    cfg_we    <= 1'b0;
  endtask

  function automatic lmcf_pkg::in_item_t make_cmd(input logic [2:0] op,
                                                  input logic [2:0] row,
                                                  input logic [1:0] disp,
                                                  input logic [4:0] col,
                                                  input logic pix,
                                                  input logic [7:0] bits,
                                                  input logic [3:0] addr,
                                                  input logic [7:0] data);
    lmcf_pkg::in_item_t c;
    c.op            = op;
    c.row_index     = row;
    c.display_index = disp;
    c.column_index  = col;
    c.pixel_on      = pix;
    c.row_bits      = bits;
    c.reg_address   = addr;
    c.reg_data      = data;
    return c;
  endfunction

  function automatic lmcf_pkg::in_item_t random_cmd();
    lmcf_pkg::in_item_t c;
    int                 pick;
    c = make_cmd(3'($urandom), 3'($urandom), 2'($urandom), 5'($urandom),
                 1'($urandom), 8'($urandom), 4'($urandom), 8'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 28)      c.op = lmcf_pkg::OP_SET_ROW;
    else if (pick < 54) c.op = lmcf_pkg::OP_SET_DOT;
    else if (pick < 64) c.op = lmcf_pkg::OP_BROADCAST;
    else if (pick < 71) c.op = lmcf_pkg::OP_SHIFT_LEFT;
    else if (pick < 78) c.op = lmcf_pkg::OP_SHIFT_RIGHT;
    else if (pick < 85) c.op = lmcf_pkg::OP_REFRESH;
    else if (pick < 92) c.op = lmcf_pkg::OP_CLEAR;
    else                c.op = OP_UNUSED;
    return c;
  endfunction

  // Row and dot writes at the corners of the buffer and inside it
  task automatic test_row_and_dot_writes();
    send_cmd(make_cmd(lmcf_pkg::OP_SET_ROW, 3'd0, 2'd0, 5'd0, 1'b0, 8'hFF, 4'h0, 8'h00));
    send_cmd(make_cmd(lmcf_pkg::OP_SET_ROW, 3'd7, 2'd3, 5'd0, 1'b0, 8'h01, 4'h0, 8'h00));
    send_cmd(make_cmd(lmcf_pkg::OP_SET_ROW, 3'd3, 2'd1, 5'd0, 1'b0, 8'hA5, 4'h0, 8'h00));
    send_cmd(make_cmd(lmcf_pkg::OP_SET_ROW, 3'd7, 2'd0, 5'd0, 1'b0, 8'h80, 4'h0, 8'h00));
    send_cmd(make_cmd(lmcf_pkg::OP_SET_ROW, 3'd5, 2'd3, 5'd0, 1'b0, 8'h80, 4'h0, 8'h00));
    pause_sender(3);
    send_cmd(make_cmd(lmcf_pkg::OP_SET_DOT, 3'd0, 2'd0, 5'd0,  1'b0, 8'h00, 4'h0, 8'h00));
    send_cmd(make_cmd(lmcf_pkg::OP_SET_DOT, 3'd7, 2'd0, 5'd31, 1'b1, 8'h00, 4'h0, 8'h00));
    send_cmd(make_cmd(lmcf_pkg::OP_SET_DOT, 3'd4, 2'd0, 5'd8,  1'b1, 8'h00, 4'h0, 8'h00));
    send_cmd(make_cmd(lmcf_pkg::OP_SET_DOT, 3'd2, 2'd0, 5'd7,  1'b1, 8'h00, 4'h0, 8'h00));
    // hold off until everything so far has come out
    wait_drained();
  endtask

  // Shifts carry across display boundaries; refresh reads the result back
  task automatic test_shifts_and_refresh();
    send_cmd(make_cmd(lmcf_pkg::OP_SHIFT_LEFT,  3'd0, 2'd0, 5'd0, 1'b0, 8'h00, 4'h0, 8'h00));
    send_cmd(make_cmd(lmcf_pkg::OP_SHIFT_RIGHT, 3'd0, 2'd0, 5'd0, 1'b0, 8'h00, 4'h0, 8'h00));
    send_cmd(make_cmd(lmcf_pkg::OP_SHIFT_RIGHT, 3'd0, 2'd0, 5'd0, 1'b0, 8'h00, 4'h0, 8'h00));
    pause_sender(20);
    send_cmd(make_cmd(lmcf_pkg::OP_REFRESH,     3'd0, 2'd0, 5'd0, 1'b0, 8'h00, 4'h0, 8'h00));
    wait_drained();
  endtask

  // Broadcasts, an unused opcode with every field high, clear, then a refresh and a row write
  task automatic test_broadcast_clear_unused();
    send_cmd(make_cmd(lmcf_pkg::OP_BROADCAST, 3'd0, 2'd0, 5'd0, 1'b0, 8'h00, 4'h0, 8'h00));
    send_cmd(make_cmd(lmcf_pkg::OP_BROADCAST, 3'd7, 2'd3, 5'd31, 1'b1, 8'hFF, 4'hF, 8'hFF));
    send_cmd(make_cmd(OP_UNUSED,              3'd7, 2'd3, 5'd31, 1'b1, 8'hFF, 4'hF, 8'hFF));
    send_cmd(make_cmd(lmcf_pkg::OP_CLEAR,     3'd0, 2'd0, 5'd0, 1'b0, 8'h00, 4'h0, 8'h00));
    send_cmd(make_cmd(lmcf_pkg::OP_REFRESH,   3'd0, 2'd0, 5'd0, 1'b0, 8'h00, 4'h0, 8'h00));
    send_cmd(make_cmd(lmcf_pkg::OP_SET_ROW,   3'd4, 2'd2, 5'd0, 1'b0, 8'h5A, 4'h0, 8'h00));
    wait_drained();
  endtask

  // Inverted view: row data flips, clear and broadcast do not
  task automatic test_inverted_view();
    write_invert(1'b1);
    send_cmd(make_cmd(lmcf_pkg::OP_SET_ROW,   3'd1, 2'd2, 5'd0,  1'b0, 8'h3C, 4'h0, 8'h00));
    send_cmd(make_cmd(lmcf_pkg::OP_SET_DOT,   3'd1, 2'd0, 5'd17, 1'b1, 8'h00, 4'h0, 8'h00));
    send_cmd(make_cmd(lmcf_pkg::OP_REFRESH,   3'd0, 2'd0, 5'd0,  1'b0, 8'h00, 4'h0, 8'h00));
    send_cmd(make_cmd(lmcf_pkg::OP_BROADCAST, 3'd0, 2'd0, 5'd0,  1'b0, 8'h00, 4'hC, 8'h01));
    send_cmd(make_cmd(lmcf_pkg::OP_CLEAR,     3'd0, 2'd0, 5'd0,  1'b0, 8'h00, 4'h0, 8'h00));
    wait_drained();
    write_invert(1'b0);
  endtask

  // Random bursts with random gaps, full drains now and then
  task automatic test_random_traffic(input int n_items, input logic invert_value);
    lmcf_pkg::in_item_t cmd;
    int                 counted;
    int                 burst_len;
    wait_drained();
    write_invert(invert_value);
    counted = 0;
    while (counted < n_items) begin
      burst_len = $urandom_range(1, 16);
      while (burst_len > 0 && counted < n_items) begin
        cmd = random_cmd();
        send_cmd(cmd);
        counted++;
        burst_len--;
      end
      case ($urandom_range(0, 9))
        0:       wait_drained();
        1, 2:    ;
        default: pause_sender($urandom_range(1, 8));
      endcase
    end
  endtask

  initial begin
    logic phase_invert [PHASES];
    phase_invert = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
    phase_invert[3] = 1'($urandom);
    for (int r = 0; r < lmcf_pkg::ROWS; r++)
      for (int d = 0; d < lmcf_pkg::MAX_DISPLAYS; d++) shadow_rows[r][d] = 8'h00;
    invert_on = 1'b0;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_row_and_dot_writes();
    test_shifts_and_refresh();
    test_broadcast_clear_unused();
    test_inverted_view();
    for (int p = 0; p < PHASES; p++)
      test_random_traffic(RANDOM_ITEMS / PHASES, phase_invert[p]);
    wait_drained();

    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
